FILE: rtl/mbn_pkg.sv
// Shared types and constants of the bounding box normalizer.
package mbn_pkg;

  // Width of the stored reciprocal of the largest extent
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP_MAX = '1;

  // Command kinds sorted by the front end
  typedef enum logic [1:0] {
    CMD_MEASURE,
    CMD_MEASURE_END,
    CMD_TRANSFORM,
    CMD_TRANSFORM_END
  } cmd_kind_e;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic      valid;
    cmd_kind_e kind;
  } cmd_status_t;

  // Reciprocal unit status
  typedef struct packed {
    logic busy;
    logic done;
  } recip_status_t;

endpackage

FILE: rtl/mbn_front.sv
// Front end: accepts vertices, sorts them into command kinds and queues them.
module mbn_front import mbn_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] z_i,
  input  logic                         last_i,
  output cmd_status_t                  cmd_o,
  output logic signed [COORD_BITS-1:0] cmd_x_o,
  output logic signed [COORD_BITS-1:0] cmd_y_o,
  output logic signed [COORD_BITS-1:0] cmd_z_o,
  input  logic                         pop_i
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  cmd_kind_e                    kind_mem [DEPTH];
  logic signed [COORD_BITS-1:0] x_mem    [DEPTH];
  logic signed [COORD_BITS-1:0] y_mem    [DEPTH];
  logic signed [COORD_BITS-1:0] z_mem    [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  cmd_kind_e        kind;

  assign in_ready_o = (count_q != CNT_W'(DEPTH));
  assign push       = in_valid_i & in_ready_o;

  // Classify the incoming vertex
  always_comb begin
    if (opcode_i) begin
      kind = last_i ? CMD_TRANSFORM_END : CMD_TRANSFORM;
    end else begin
      kind = last_i ? CMD_MEASURE_END : CMD_MEASURE;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_mem[wr_ptr_q] <= kind;
      x_mem[wr_ptr_q]    <= x_i;
      y_mem[wr_ptr_q]    <= y_i;
      z_mem[wr_ptr_q]    <= z_i;
    end
  end

  // Pointers and fill count
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue head
  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.kind  = kind_mem[rd_ptr_q];
  assign cmd_x_o     = x_mem[rd_ptr_q];
  assign cmd_y_o     = y_mem[rd_ptr_q];
  assign cmd_z_o     = z_mem[rd_ptr_q];

endmodule

FILE: rtl/mbn_recip.sv
// Radix-2 restoring divider forming round(2^(2*FRAC_BITS) / extent), saturated.
module mbn_recip import mbn_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output recip_status_t         stat_o,
  output logic [RECIP_W-1:0]    quot_o
);

  localparam int NUM_W = ((2*FRAC_BITS > COORD_BITS-1) ? 2*FRAC_BITS : COORD_BITS-1) + 1;
  localparam int CNT_W = $clog2(NUM_W+1);
  localparam int QW    = (NUM_W > RECIP_W) ? NUM_W : RECIP_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Numerator shifts out at the top while quotient bits enter at the bottom
  logic [NUM_W-1:0]      num_q;
  logic [COORD_BITS-1:0] rem_q;
  logic [COORD_BITS-1:0] div_q;
  logic [COORD_BITS:0]   r_shift;
  logic [COORD_BITS:0]   r_sub;
  logic                  ge;
  logic [QW-1:0]         q_ext;

  assign r_shift = {rem_q, num_q[NUM_W-1]};
  assign r_sub   = r_shift - {1'b0, div_q};
  assign ge      = (r_shift >= {1'b0, div_q});

  // Step counter
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // One quotient bit per cycle; numerator carries the rounding half
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= (NUM_W'(1) << (2*FRAC_BITS)) + NUM_W'(divisor_i >> 1);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? r_sub[COORD_BITS-1:0] : r_shift[COORD_BITS-1:0];
    end
  end

  // Saturate to the reciprocal width
  assign q_ext  = QW'(num_q);
  assign quot_o = (q_ext > QW'(RECIP_MAX)) ? RECIP_MAX : q_ext[RECIP_W-1:0];

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/mbn_back.sv
// Back end: bounds tracking, extent selection and per-axis scaling of vertices.
module mbn_back import mbn_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_status_t                  cmd_i,
  input  logic signed [COORD_BITS-1:0] cmd_x_i,
  input  logic signed [COORD_BITS-1:0] cmd_y_i,
  input  logic signed [COORD_BITS-1:0] cmd_z_i,
  output logic                         pop_o,
  output logic                         recip_start_o,
  output logic [COORD_BITS-1:0]        recip_div_o,
  input  recip_status_t                recip_stat_i,
  input  logic [RECIP_W-1:0]           recip_quot_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [COORD_BITS-1:0]        norm_x_o,
  output logic [COORD_BITS-1:0]        norm_y_o,
  output logic [COORD_BITS-1:0]        norm_z_o,
  output logic                         degenerate_o,
  output logic                         last_o
);

  localparam int DD_W  = COORD_BITS + 2;
  localparam int LIMB_W = 32;
  localparam int MAG_W = 2 * LIMB_W;
  localparam int ACC_W = MAG_W + LIMB_W;
  localparam int SENTINEL_INT = 1000;

  localparam longint CMAX     = (longint'(1) <<< (COORD_BITS-1)) - 1;
  localparam longint SENT_RAW = longint'(SENTINEL_INT) <<< FRAC_BITS;
  localparam longint SENT     = (SENT_RAW > CMAX) ? CMAX : SENT_RAW;
  localparam longint SENT_NEG = (SENT < CMAX) ? -SENT : -SENT - 1;
  localparam logic signed [COORD_BITS-1:0] LOW_INIT  = COORD_BITS'(SENT);
  localparam logic signed [COORD_BITS-1:0] HIGH_INIT = COORD_BITS'(SENT_NEG);

  localparam logic [ACC_W-1:0] RND     = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] LIM_POS = ACC_W'(CMAX);
  localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(CMAX) + 1'b1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXT    = 4'd1;
  localparam logic [3:0] S_MAX    = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_MAG    = 4'd4;
  localparam logic [3:0] S_MUL_LO = 4'd5;
  localparam logic [3:0] S_MUL_HI = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_SAT    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       out_valid_q, out_valid_d;

  logic signed [COORD_BITS-1:0] low_x_q, low_x_d, high_x_q, high_x_d;
  logic signed [COORD_BITS-1:0] low_y_q, low_y_d, high_y_q, high_y_d;
  logic signed [COORD_BITS-1:0] low_z_q, low_z_d, high_z_q, high_z_d;
  logic [RECIP_W-1:0]           inv_q, inv_d;
  logic                         zero_q, zero_d;

  logic is_xf;

  // Datapath registers
  logic [DD_W-1:0]       dd_x_q, dd_y_q, dd_z_q;
  logic                  last_q;
  logic [COORD_BITS-1:0] ext_x_q, ext_y_q, ext_z_q;
  logic                  neg_q;
  logic [MAG_W-1:0]      mag_q;
  logic [MAG_W-1:0]      prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [COORD_BITS-1:0] norm_x_q, norm_y_q, norm_z_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic                  out_deg_q, out_last_q;

  // Combinational helpers
  logic [DD_W-1:0]       dd_x, dd_y, dd_z;
  logic [COORD_BITS:0]   dy_half;
  logic [COORD_BITS:0]   ex_full, ey_full, ez_full;
  logic [COORD_BITS-1:0] e_xy, e_max;
  logic [DD_W-1:0]       dd_sel, mag;
  logic [LIMB_W-1:0]     limb;
  logic [MAG_W-1:0]      limb_prod;
  logic [ACC_W-1:0]      q_full, lim, q_sat;
  logic [COORD_BITS-1:0] q_c, res;
  logic                  out_load;

  assign is_xf = (cmd_i.kind == CMD_TRANSFORM) || (cmd_i.kind == CMD_TRANSFORM_END);

  // Doubled differences against the centers and the y base
  assign dd_x = {cmd_x_i[COORD_BITS-1], cmd_x_i, 1'b0}
              - {{2{low_x_q[COORD_BITS-1]}}, low_x_q}
              - {{2{high_x_q[COORD_BITS-1]}}, high_x_q};
  assign dy_half = {cmd_y_i[COORD_BITS-1], cmd_y_i} - {low_y_q[COORD_BITS-1], low_y_q};
  assign dd_y = {dy_half, 1'b0};
  assign dd_z = {cmd_z_i[COORD_BITS-1], cmd_z_i, 1'b0}
              - {{2{low_z_q[COORD_BITS-1]}}, low_z_q}
              - {{2{high_z_q[COORD_BITS-1]}}, high_z_q};

  // Extents and their maximum
  assign ex_full = {high_x_q[COORD_BITS-1], high_x_q} - {low_x_q[COORD_BITS-1], low_x_q};
  assign ey_full = {high_y_q[COORD_BITS-1], high_y_q} - {low_y_q[COORD_BITS-1], low_y_q};
  assign ez_full = {high_z_q[COORD_BITS-1], high_z_q} - {low_z_q[COORD_BITS-1], low_z_q};
  assign e_xy  = (ext_y_q > ext_x_q) ? ext_y_q : ext_x_q;
  assign e_max = (ext_z_q > e_xy) ? ext_z_q : e_xy;
  assign recip_div_o = e_max;

  // Magnitude of the selected axis
  always_comb begin
    case (axis_q)
      AXIS_X:  dd_sel = dd_x_q;
      AXIS_Y:  dd_sel = dd_y_q;
      AXIS_Z:  dd_sel = dd_z_q;
      default: dd_sel = dd_x_q;
    endcase
    mag = dd_sel[DD_W-1] ? (~dd_sel + 1'b1) : dd_sel;
  end

  // Shared limb multiplier: low limb first, then high limb
  assign limb      = (state_q == S_MUL_HI) ? mag_q[MAG_W-1:LIMB_W] : mag_q[LIMB_W-1:0];
  assign limb_prod = MAG_W'(limb) * MAG_W'(inv_q);

  // Round, saturate and restore the sign
  always_comb begin
    q_full = acc_q >> (FRAC_BITS + 1);
    lim    = neg_q ? LIM_NEG : LIM_POS;
    q_sat  = (q_full > lim) ? lim : q_full;
    q_c    = q_sat[COORD_BITS-1:0];
    res    = neg_q ? (~q_c + 1'b1) : q_c;
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer and architectural state
  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    pop_o         = 1'b0;
    recip_start_o = 1'b0;
    out_valid_d   = out_valid_q & ~out_ready_i;
    low_x_d  = low_x_q;  high_x_d = high_x_q;
    low_y_d  = low_y_q;  high_y_d = high_y_q;
    low_z_d  = low_z_q;  high_z_d = high_z_q;
    inv_d    = inv_q;
    zero_d   = zero_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          pop_o = 1'b1;
          if (is_xf) begin
            axis_d  = AXIS_X;
            state_d = S_MAG;
          end else begin
            if (cmd_x_i < low_x_q)  low_x_d  = cmd_x_i;
            if (cmd_x_i > high_x_q) high_x_d = cmd_x_i;
            if (cmd_y_i < low_y_q)  low_y_d  = cmd_y_i;
            if (cmd_y_i > high_y_q) high_y_d = cmd_y_i;
            if (cmd_z_i < low_z_q)  low_z_d  = cmd_z_i;
            if (cmd_z_i > high_z_q) high_z_d = cmd_z_i;
            if (cmd_i.kind == CMD_MEASURE_END) state_d = S_EXT;
          end
        end
      end
      S_EXT: state_d = S_MAX;
      S_MAX: begin
        if (e_max == '0) begin
          zero_d  = 1'b1;
          inv_d   = '0;
          state_d = S_IDLE;
        end else begin
          recip_start_o = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (recip_stat_i.done) begin
          inv_d   = recip_quot_i;
          zero_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_MAG:    state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_ACC;
      S_ACC:    state_d = S_SAT;
      S_SAT: begin
        if (axis_q == AXIS_Z) begin
          state_d = S_OUT;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_MAG;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          // End of a vertex set: restart the bounds
          if (last_q) begin
            low_x_d  = LOW_INIT;  high_x_d = HIGH_INIT;
            low_y_d  = LOW_INIT;  high_y_d = HIGH_INIT;
            low_z_d  = LOW_INIT;  high_z_d = HIGH_INIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
      low_x_q  <= LOW_INIT;  high_x_q <= HIGH_INIT;
      low_y_q  <= LOW_INIT;  high_y_q <= HIGH_INIT;
      low_z_q  <= LOW_INIT;  high_z_q <= HIGH_INIT;
      inv_q    <= '0;
      zero_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      low_x_q  <= low_x_d;  high_x_q <= high_x_d;
      low_y_q  <= low_y_d;  high_y_q <= high_y_d;
      low_z_q  <= low_z_d;  high_z_q <= high_z_d;
      inv_q    <= inv_d;
      zero_q   <= zero_d;
    end
  end

  // Datapath: two 32-bit limb products per axis, then round and saturate
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid && is_xf) begin
          dd_x_q <= dd_x;
          dd_y_q <= dd_y;
          dd_z_q <= dd_z;
          last_q <= (cmd_i.kind == CMD_TRANSFORM_END);
        end
      end
      S_EXT: begin
        ext_x_q <= ex_full[COORD_BITS-1:0];
        ext_y_q <= ey_full[COORD_BITS-1:0];
        ext_z_q <= ez_full[COORD_BITS-1:0];
      end
      S_MAG: begin
        neg_q <= dd_sel[DD_W-1];
        mag_q <= MAG_W'(mag);
      end
      S_MUL_LO: prod_q <= limb_prod;
      S_MUL_HI: begin
        acc_q  <= ACC_W'(prod_q) + RND;
        prod_q <= limb_prod;
      end
      S_ACC: acc_q <= acc_q + {prod_q, {LIMB_W{1'b0}}};
      S_SAT: begin
        case (axis_q)
          AXIS_X:  norm_x_q <= res;
          AXIS_Y:  norm_y_q <= res;
          AXIS_Z:  norm_z_q <= res;
          default: norm_x_q <= res;
        endcase
      end
      S_OUT: begin
        if (out_load) begin
          out_x_q    <= norm_x_q;
          out_y_q    <= norm_y_q;
          out_z_q    <= norm_z_q;
          out_deg_q  <= zero_q;
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign norm_x_o     = out_x_q;
  assign norm_y_o     = out_y_q;
  assign norm_z_o     = out_z_q;
  assign degenerate_o = out_deg_q;
  assign last_o       = out_last_q;

  // Checks
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> cmd_i.valid)
    else $error("queue popped while empty");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recip_stat_i.done |-> (state_q == S_DIV))
    else $error("reciprocal finished outside the divide wait");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recip_start_o |-> !recip_stat_i.busy)
    else $error("reciprocal restarted while busy");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result overwritten while output stalled");

endmodule

FILE: rtl/mesh_bbox_normalize.sv
// Top level of the bounding box normalizer: stream ports, front, back and divider.
//
//  Channel | Dir | tdata (low bit up)                  | tuser        | tlast
//  s_axis  | in  | x_coord, y_coord, z_coord, zero pad | opcode       | last_vertex
//  m_axis  | out | norm_x, norm_y, norm_z, zero pad    | degenerate   | last_out
//
// Measure vertices retire at one per cycle through a 4-entry command queue while
// the back end is idle. A measure vertex with tlast then runs the restoring
// divider over NUM_W = max(2*FRAC_BITS, COORD_BITS-1) + 1 (33 at the defaults)
// bits, one bit per cycle. Per axis, a transform vertex runs two 32x32 limb
// products, an add and a rounding step on one shared multiplier; then it is output.
// Reset loads the bound sentinels and clears the reciprocal; no clearing pass.
// The output register holds a stalled result while the queue keeps taking vertices.
module mesh_bbox_normalize import mbn_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x_coord, y_coord, z_coord from bit 0 up, zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic s_axis_tuser,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // norm_x, norm_y, norm_z from bit 0 up, zero padded to bytes
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser,
  output logic m_axis_tlast
);

  localparam int DATA_W = ((3*COORD_BITS+7)/8)*8;

  cmd_status_t                  cmd;
  logic signed [COORD_BITS-1:0] cmd_x, cmd_y, cmd_z;
  logic                         pop;
  logic                         recip_start;
  logic [COORD_BITS-1:0]        recip_div;
  recip_status_t                recip_stat;
  logic [RECIP_W-1:0]           recip_quot;
  logic [COORD_BITS-1:0]        norm_x, norm_y, norm_z;

  mbn_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .opcode_i  (s_axis_tuser),
    .x_i       (s_axis_tdata[COORD_BITS-1:0]),
    .y_i       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .z_i       (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .last_i    (s_axis_tlast),
    .cmd_o     (cmd),
    .cmd_x_o   (cmd_x),
    .cmd_y_o   (cmd_y),
    .cmd_z_o   (cmd_z),
    .pop_i     (pop)
  );

  mbn_recip #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (recip_start),
    .divisor_i(recip_div),
    .stat_o   (recip_stat),
    .quot_o   (recip_quot)
  );

  mbn_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_x_i      (cmd_x),
    .cmd_y_i      (cmd_y),
    .cmd_z_i      (cmd_z),
    .pop_o        (pop),
    .recip_start_o(recip_start),
    .recip_div_o  (recip_div),
    .recip_stat_i (recip_stat),
    .recip_quot_i (recip_quot),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .norm_x_o     (norm_x),
    .norm_y_o     (norm_y),
    .norm_z_o     (norm_z),
    .degenerate_o (m_axis_tuser),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = DATA_W'({norm_z, norm_y, norm_x});

endmodule

FILE: tb/mbn_norm_checker.sv
`timescale 1ns / 1ps
// Checker of the bounding box normalizer: tracks bounds, predicts results and compares them.
module mbn_norm_checker import mbn_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int DATA_W     = ((3*COORD_BITS+7)/8)*8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  // x_coord, y_coord, z_coord from bit 0 up
  input  logic [DATA_W-1:0] s_tdata_i,
  // opcode
  input  logic              s_tuser_i,
  input  logic              s_tlast_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  // norm_x, norm_y, norm_z from bit 0 up
  input  logic [DATA_W-1:0] m_tdata_i,
  // degenerate
  input  logic              m_tuser_i,
  input  logic              m_tlast_i,
  output int                pending_o,
  output int                errors_o
);

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS-1)) - 1;
  localparam longint SENT_RAW  = longint'(1000) <<< FRAC_BITS;
  // Sentinel clamps to the coordinate range when the format is too narrow
  localparam longint SENT_POS  = (SENT_RAW > COORD_MAX) ? COORD_MAX : SENT_RAW;
  localparam longint SENT_NEG  = (SENT_POS < COORD_MAX) ? -SENT_POS : -SENT_POS - 1;
  localparam int     REPORT_CAP = 200;

  typedef struct packed {
    logic [COORD_BITS-1:0] norm_x;
    logic [COORD_BITS-1:0] norm_y;
    logic [COORD_BITS-1:0] norm_z;
    logic                  degenerate;
    logic                  last_out;
  } norm_result_t;

  // Predictor state
  longint             low_x, high_x, low_y, high_y, low_z, high_z;
  logic [RECIP_W-1:0] inv_extent;
  logic               zero_extent;
  norm_result_t       result_q[$];
  int                 mismatch_cnt;

  task automatic reload_bounds();
    low_x  = SENT_POS;
    low_y  = SENT_POS;
    low_z  = SENT_POS;
    high_x = SENT_NEG;
    high_y = SENT_NEG;
    high_z = SENT_NEG;
  endtask

  // (dd / 2) * inv_extent, rounded half away from zero, saturated to the coordinate range
  function automatic longint scale_half(input longint dd);
    logic        neg;
    logic [127:0] mag;
    logic [127:0] prod;
    longint      lim;
    neg  = (dd < 0);
    mag  = neg ? 128'(-dd) : 128'(dd);
    prod = (mag * 128'(inv_extent) + (128'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
    lim  = neg ? COORD_MAX + 1 : COORD_MAX;
    if (prod > 128'(lim)) prod = 128'(lim);
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (mismatch_cnt < REPORT_CAP)
      $error("%s mismatch: expected %0h actual %0h", field, exp_v, act_v);
    mismatch_cnt++;
  endtask

  // Watch both channels on each edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic signed [COORD_BITS-1:0] xs, ys, zs;
    longint       x, y, z, ext;
    logic [127:0] recip;
    norm_result_t pred;
    norm_result_t got;
    if (!rst_ni) begin
      reload_bounds();
      inv_extent   = '0;
      zero_extent  = 1'b0;
      result_q.delete();
      mismatch_cnt = 0;
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      // Input transaction: update the bounds or predict a result
      if (s_tvalid_i && s_tready_i) begin
        xs = s_tdata_i[0 +: COORD_BITS];
        ys = s_tdata_i[COORD_BITS +: COORD_BITS];
        zs = s_tdata_i[2*COORD_BITS +: COORD_BITS];
        x  = longint'(xs);
        y  = longint'(ys);
        z  = longint'(zs);
        if (!s_tuser_i) begin
          if (x < low_x)  low_x  = x;
          if (x > high_x) high_x = x;
          if (y < low_y)  low_y  = y;
          if (y > high_y) high_y = y;
          if (z < low_z)  low_z  = z;
          if (z > high_z) high_z = z;
          if (s_tlast_i) begin
            // largest extent, true maximum over the three axes
            ext = high_x - low_x;
            if (high_y - low_y > ext) ext = high_y - low_y;
            if (high_z - low_z > ext) ext = high_z - low_z;
            if (ext <= 0) begin
              zero_extent = 1'b1;
              inv_extent  = '0;
            end else begin
              recip = ((128'(1) << (2*FRAC_BITS)) + 128'(ext >>> 1)) / 128'(ext);
              zero_extent = 1'b0;
              inv_extent  = (recip > 128'(RECIP_MAX)) ? RECIP_MAX : recip[RECIP_W-1:0];
            end
          end
        end else begin
          if (zero_extent) begin
            pred.norm_x = '0;
            pred.norm_y = '0;
            pred.norm_z = '0;
          end else begin
            pred.norm_x = COORD_BITS'(scale_half(2*x - low_x - high_x));
            pred.norm_y = COORD_BITS'(scale_half(2*(y - low_y)));
            pred.norm_z = COORD_BITS'(scale_half(2*z - low_z - high_z));
          end
          pred.degenerate = zero_extent;
          pred.last_out   = s_tlast_i;
          result_q.push_back(pred);
          if (s_tlast_i) reload_bounds();
        end
      end

      // Output transaction: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got.norm_x     = m_tdata_i[0 +: COORD_BITS];
        got.norm_y     = m_tdata_i[COORD_BITS +: COORD_BITS];
        got.norm_z     = m_tdata_i[2*COORD_BITS +: COORD_BITS];
        got.degenerate = m_tuser_i;
        got.last_out   = m_tlast_i;
        if (result_q.size() == 0) begin
          if (mismatch_cnt < REPORT_CAP)
            $error("result transaction with nothing expected: tdata %0h", m_tdata_i);
          mismatch_cnt++;
        end else begin
          pred = result_q.pop_front();
          if (got.norm_x != pred.norm_x)
            flag_mismatch("norm_x", 64'(pred.norm_x), 64'(got.norm_x));
          if (got.norm_y != pred.norm_y)
            flag_mismatch("norm_y", 64'(pred.norm_y), 64'(got.norm_y));
          if (got.norm_z != pred.norm_z)
            flag_mismatch("norm_z", 64'(pred.norm_z), 64'(got.norm_z));
          if (got.degenerate != pred.degenerate)
            flag_mismatch("degenerate", 64'(pred.degenerate), 64'(got.degenerate));
          if (got.last_out != pred.last_out)
            flag_mismatch("last_out", 64'(pred.last_out), 64'(got.last_out));
        end
      end
      pending_o <= result_q.size();
      errors_o  <= mismatch_cnt;
    end
  end

endmodule

FILE: tb/tb_mesh_bbox_normalize.sv
`timescale 1ns / 1ps
// Testbench top of the bounding box normalizer: stimulus, idling and verdict.
module tb_mesh_bbox_normalize;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = ((3*COORD_BITS+7)/8)*8;

  localparam logic OP_MEASURE   = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;

  // Handy Q16.16 values
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_HALF    = 32'h0000_8000;
  localparam logic [31:0] Q_THREE   = 32'h0003_0000;
  localparam logic [31:0] C_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN     = 32'h8000_0000;
  localparam logic [31:0] SENT_P    = 32'h03E8_0000;
  localparam logic [31:0] SENT_N    = 32'hFC18_0000;
  localparam int          SPAN      = 1200 << 16;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  int pending;
  int errors;
  int src_idle_pct  = 24;
  int sink_idle_pct = 67;
  int sent_cnt      = 0;
  int cycle_cnt     = 0;

  always #6 clk_i = ~clk_i;

  mesh_bbox_normalize #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mbn_norm_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Coordinate flavors: full range, moderate, tight cluster around base, corner values
  function automatic logic [31:0] rand_coord(input int mode, input logic [31:0] base);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(2*SPAN)) - SPAN);
      2: return base + 32'($urandom_range(6)) - 32'd3;
      default: begin
        case ($urandom_range(5))
          0: return C_MIN;
          1: return C_MAX;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return SENT_P;
          default: return SENT_N;
        endcase
      end
    endcase
  endfunction

  // One vertex transaction, with random gaps in front
  task automatic send_vertex(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({z, y, x});
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Hold off the sender until every predicted result is out
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Measure pass then transform pass; optionally an early measure end or an open transform run
  task automatic send_frame(input bit split_measure, input bit open_end);
    int          n_meas, n_xf, m_mode, t_mode;
    logic [31:0] base;
    n_meas = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    n_xf   = $urandom_range(1, 6);
    m_mode = $urandom_range(3);
    t_mode = $urandom_range(3);
    base   = rand_coord(1, 32'h0);
    for (int i = 0; i < n_meas; i++) begin
      send_vertex(OP_MEASURE, rand_coord(m_mode, base), rand_coord(m_mode, base),
                  rand_coord(m_mode, base), (i == n_meas-1) || (split_measure && i == 0));
    end
    for (int i = 0; i < n_xf; i++) begin
      send_vertex(OP_TRANSFORM, rand_coord(t_mode, base), rand_coord(t_mode, base),
                  rand_coord(t_mode, base), !open_end && (i == n_xf-1));
    end
  endtask

  // Mostly clean frames, some broken ones, some loose noise
  task automatic run_random(input int upto);
    int pick;
    while (sent_cnt < upto) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(1'b0, 1'b0);
      end else if (pick < 87) begin
        send_frame(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_vertex(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                      1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Transform straight after reset: zero reciprocal, not degenerate
    send_vertex(OP_TRANSFORM, C_MAX, C_MIN, 32'h0, 1'b0);
    // Single vertex at the origin: zero extent
    send_vertex(OP_MEASURE, 32'h0, 32'h0, 32'h0, 1'b1);
    send_vertex(OP_TRANSFORM, Q_ONE, 32'hFFFF_FFFF, C_MAX, 1'b1);
    // Extent of one LSB: reciprocal saturates, outputs saturate both ways
    send_vertex(OP_MEASURE, 32'h0, 32'h0, 32'h0, 1'b0);
    send_vertex(OP_MEASURE, 32'h1, 32'h0, 32'h0, 1'b1);
    send_vertex(OP_TRANSFORM, C_MAX, C_MAX, C_MIN, 1'b0);
    send_vertex(OP_TRANSFORM, C_MIN, C_MIN, C_MAX, 1'b1);
    // Tied x and y extents
    send_vertex(OP_MEASURE, Q_NEG_ONE, Q_NEG_ONE, 32'h0, 1'b0);
    send_vertex(OP_MEASURE, Q_ONE, Q_ONE, 32'h0, 1'b1);
    send_vertex(OP_TRANSFORM, Q_ONE, 32'h0, Q_HALF, 1'b0);
    send_vertex(OP_TRANSFORM, 32'h1, 32'hFFFF_FFFF, 32'h3, 1'b1);
    // Two measure ends with no transform between: bounds keep growing
    send_vertex(OP_MEASURE, 32'h0, 32'h0, 32'h0, 1'b1);
    send_vertex(OP_MEASURE, Q_THREE, 32'h0, 32'h0, 1'b1);
    send_vertex(OP_TRANSFORM, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    // Full coordinate span
    send_vertex(OP_MEASURE, C_MIN, C_MIN, C_MIN, 1'b0);
    send_vertex(OP_MEASURE, C_MAX, C_MAX, C_MAX, 1'b1);
    send_vertex(OP_TRANSFORM, C_MAX, C_MIN, 32'h0, 1'b0);
    send_vertex(OP_TRANSFORM, SENT_P, SENT_N, 32'hFFFF_FFFF, 1'b1);
    // Transform on reloaded sentinels with the old reciprocal
    send_vertex(OP_TRANSFORM, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    wait_for_results();

    // Sender idles less than the receiver
    run_random(sent_cnt + 270);
    wait_for_results();

    // Receiver idles less than the sender
    src_idle_pct  = 67;
    sink_idle_pct = 24;
    run_random(sent_cnt + 270);
    wait_for_results();

    // Full rate on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(sent_cnt + 260);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
